// ----- rtl/esutc_pkg.sv -----
// Shared widths and constants for the epoch-seconds to UTC calendar converter.
`timescale 1ns / 1ps
`default_nettype none

package esutc_pkg;

	// Field widths
	localparam int SECS_W  = 32;
	localparam int SEC_W   = 6;
	localparam int MIN_W   = 6;
	localparam int HOUR_W  = 5;
	localparam int MDAY_W  = 5;
	localparam int MON_W   = 4;
	localparam int YEAR_W  = 8;
	localparam int WDAY_W  = 3;
	localparam int YDAY_W  = 9;

	// Whole days added so the second count is never negative (24856 days)
	localparam logic [32:0] DayBias    = 33'd2147558400;
	localparam logic [15:0] DayBiasDays = 16'd24856;

	// Reciprocals: floor(x / d) = (x * M) >> S over the stated input width
	localparam logic [26:0] RecipDay   = 27'd101806633; // /675, 26-bit x, S 36
	localparam logic [18:0] RecipCycle = 19'd367469;    // /1461, 18-bit x, S 29
	localparam logic [16:0] RecipWeek  = 17'd74899;     // /7, 16-bit x, S 19
	localparam logic [17:0] RecipMin   = 18'd139811;    // /60, 17-bit x, S 23
	localparam logic [11:0] RecipHour  = 12'd2185;      // /60, 11-bit x, S 17
	localparam logic [12:0] RecipMon   = 13'd6854;      // /153, 12-bit x, S 20
	localparam logic [8:0]  RecipFive  = 9'd410;        // /5, 8-bit x, S 11

	// Calendar constants, with day bias folded in where the day is offset
	localparam logic [17:0] CycleBias  = 18'd2611;  // 102035 - 4 * 24856
	localparam logic [16:0] YdayBias   = 17'd712;   // 25568 - 24856
	localparam logic [15:0] WdayBias   = 16'd5;     // 24861 - 24856 (mod 7)
	localparam logic [11:0] MonBias    = 12'd8;
	localparam logic [YDAY_W-1:0] DaysLeapYear = 9'd366;
	localparam logic [MON_W-1:0]  MonthsPerYear = 4'd12;

endpackage

`default_nettype wire

// ----- rtl/epoch_seconds_to_utc_calendar_unit.sv -----
// Seven-stage pipelined converter from signed epoch seconds to UTC calendar fields.
// Depth: 7 register stages, s1 through s7, between the accepted input and the outputs.
// Throughput: one request per cycle unless out_ready stalls; a full stage holds while the stage after it cannot move.
// Stall: in_ready is the ready chain through all seven stages back from out_ready.
// Reset: arst_n clears every stage valid bit at once; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module epoch_seconds_to_utc_calendar_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic signed [esutc_pkg::SECS_W-1:0] unix_seconds,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [esutc_pkg::SEC_W-1:0]           second,
	output logic [esutc_pkg::MIN_W-1:0]           minute,
	output logic [esutc_pkg::HOUR_W-1:0]          hour,
	output logic [esutc_pkg::MDAY_W-1:0]          day_of_month,
	output logic [esutc_pkg::MON_W-1:0]           month,
	output logic [esutc_pkg::YEAR_W-1:0]          year_offset,
	output logic [esutc_pkg::WDAY_W-1:0]          weekday,
	output logic [esutc_pkg::YDAY_W-1:0]          day_of_year
);
	import esutc_pkg::*;

	localparam int NSTAGE = 7;

	logic [NSTAGE:1] vld_q;
	logic [NSTAGE:1] adv;

	// Stage payloads
	logic [25:0] w_s1, w_s2;
	logic [6:0]  lo_s1, lo_s2;
	logic [15:0] dayp_s2, dayp_s3;
	logic [16:0] tod_s3, tod_s4;
	logic [YEAR_W-1:0] yr_s3, yr_s4, yr_s5;
	logic [12:0] wq_s3;
	logic [YDAY_W-1:0] yday_s4, yday_s5;
	logic [WDAY_W-1:0] wday_s4, wday_s5, wday_s6, wday_s7;
	logic [10:0] tmin_s4, tmin_s5;
	logic [11:0] acc_s5;
	logic [MON_W-1:0] mon_s5;
	logic [SEC_W-1:0] sec_s5, sec_s6, sec_s7;
	logic [HOUR_W-1:0] hr_s5, hr_s6, hr_s7;
	logic [7:0] rem_s6;
	logic [MIN_W-1:0] min_s6, min_s7;
	logic [MON_W-1:0] mon_s6, mon_s7;
	logic [YEAR_W-1:0] yr_s6, yr_s7;
	logic [YDAY_W-1:0] yday_s6, yday_s7;
	logic [MDAY_W-1:0] mday_s7;

	// Combinational results per stage
	logic [32:0] biased;
	logic [52:0] day_prod;
	logic [25:0] day_mul;
	logic [25:0] rem_day;
	logic [17:0] cyc;
	logic [36:0] yr_prod;
	logic [15:0] wx;
	logic [31:0] wq_prod;
	logic [16:0] yd_mul;
	logic [16:0] yday_full;
	logic [16:0] wx4;
	logic [16:0] wday_full;
	logic [34:0] tmin_prod;
	logic [11:0] acc;
	logic [23:0] mon_prod;
	logic [16:0] sec_full;
	logic [22:0] hr_prod;
	logic [11:0] rem_full;
	logic [10:0] min_full;
	logic [MON_W-1:0] mon_adj;
	logic [YEAR_W-1:0] yr_adj;
	logic [YDAY_W-1:0] yday_adj;
	logic [16:0] mday_prod;

	// Ready chain: a stage moves when it is empty or the next one moves
	always_comb begin
		adv[NSTAGE] = !vld_q[NSTAGE] || out_ready;
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign in_ready  = adv[1];
	assign out_valid = vld_q[NSTAGE];

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NSTAGE; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: bias to a non-negative count, split off the power-of-two part of 86400
	assign biased = 33'(unix_seconds) + DayBias;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			w_s1  <= biased[32:7];
			lo_s1 <= biased[6:0];
		end
	end

	// Stage 2: day number by reciprocal of 675
	assign day_prod = 53'(w_s1) * 53'(RecipDay);

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			dayp_s2 <= day_prod[51:36];
			w_s2    <= w_s1;
			lo_s2   <= lo_s1;
		end
	end

	// Stage 3: time of day, year from the four-year cycle, week quotient
	assign day_mul = 26'(dayp_s2) * 26'(10'd675);
	assign rem_day = w_s2 - day_mul;
	assign cyc     = {dayp_s2, 2'b00} + CycleBias;
	assign yr_prod = 37'(cyc) * 37'(RecipCycle);
	assign wx      = dayp_s2 + WdayBias;
	assign wq_prod = 32'(wx) * 32'(RecipWeek);

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			tod_s3  <= {rem_day[9:0], lo_s2};
			yr_s3   <= yr_prod[36:29];
			wq_s3   <= wq_prod[31:19];
			dayp_s3 <= dayp_s2;
		end
	end

	// Stage 4: March-based day of year, weekday, minutes of the day
	assign yd_mul    = 17'(yr_s3) * 17'(9'd365);
	assign yday_full = 17'(dayp_s3) + YdayBias - yd_mul - 17'(yr_s3[YEAR_W-1:2]);
	assign wx4       = 17'(dayp_s3) + 17'(WdayBias);
	assign wday_full = wx4 - 17'(wq_s3) * 17'(3'd7);
	assign tmin_prod = 35'(tod_s3) * 35'(RecipMin);

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			yday_s4 <= yday_full[YDAY_W-1:0];
			yr_s4   <= yr_s3;
			wday_s4 <= wday_full[WDAY_W-1:0];
			tmin_s4 <= tmin_prod[33:23];
			tod_s4  <= tod_s3;
		end
	end

	// Stage 5: month index, seconds, hours
	assign acc      = 12'(yday_s4) * 12'(3'd5) + MonBias;
	assign mon_prod = 24'(acc) * 24'(RecipMon);
	assign sec_full = tod_s4 - 17'(tmin_s4) * 17'(6'd60);
	assign hr_prod  = 23'(tmin_s4) * 23'(RecipHour);

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			acc_s5  <= acc;
			mon_s5  <= mon_prod[23:20];
			sec_s5  <= sec_full[SEC_W-1:0];
			hr_s5   <= hr_prod[21:17];
			tmin_s5 <= tmin_s4;
			yday_s5 <= yday_s4;
			yr_s5   <= yr_s4;
			wday_s5 <= wday_s4;
		end
	end

	// Stage 6: remainder within the month, minutes, wrap January and February, adjust the day of year
	assign rem_full = acc_s5 - 12'(mon_s5) * 12'(8'd153);
	assign min_full = tmin_s5 - 11'(hr_s5) * 11'(6'd60);

	always_comb begin
		mon_adj  = mon_s5;
		yr_adj   = yr_s5;
		yday_adj = yday_s5;
		priority if (mon_s5 >= MonthsPerYear) begin
			mon_adj  = mon_s5 - MonthsPerYear;
			yr_adj   = yr_s5 + 8'd1;
			yday_adj = yday_s5 - DaysLeapYear;
		end else if (yr_s5[1:0] != 2'b00) begin
			yday_adj = yday_s5 - 9'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			rem_s6  <= rem_full[7:0];
			min_s6  <= min_full[MIN_W-1:0];
			sec_s6  <= sec_s5;
			hr_s6   <= hr_s5;
			mon_s6  <= mon_adj;
			yr_s6   <= yr_adj;
			yday_s6 <= yday_adj;
			wday_s6 <= wday_s5;
		end
	end

	// Stage 7: day of month, hold results for the consumer
	assign mday_prod = 17'(rem_s6) * 17'(RecipFive);

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			mday_s7 <= mday_prod[15:11] + 5'd1;
			min_s7  <= min_s6;
			sec_s7  <= sec_s6;
			hr_s7   <= hr_s6;
			mon_s7  <= mon_s6;
			yr_s7   <= yr_s6;
			yday_s7 <= yday_s6;
			wday_s7 <= wday_s6;
		end
	end

	assign second       = sec_s7;
	assign minute       = min_s7;
	assign hour         = hr_s7;
	assign day_of_month = mday_s7;
	assign month        = mon_s7;
	assign year_offset  = yr_s7;
	assign weekday      = wday_s7;
	assign day_of_year  = yday_s7;

endmodule

`default_nettype wire

// ----- rtl/esutc_checker.sv -----
// Port-level checks for the UTC calendar converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module esutc_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_valid,
	input wire logic                                in_ready,
	input wire logic signed [esutc_pkg::SECS_W-1:0] unix_seconds,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic [esutc_pkg::SEC_W-1:0]         second,
	input wire logic [esutc_pkg::MIN_W-1:0]         minute,
	input wire logic [esutc_pkg::HOUR_W-1:0]        hour,
	input wire logic [esutc_pkg::MDAY_W-1:0]        day_of_month,
	input wire logic [esutc_pkg::MON_W-1:0]         month,
	input wire logic [esutc_pkg::YEAR_W-1:0]        year_offset,
	input wire logic [esutc_pkg::WDAY_W-1:0]        weekday,
	input wire logic [esutc_pkg::YDAY_W-1:0]        day_of_year
);
	import esutc_pkg::*;

	// A waiting request keeps its timestamp until accepted
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(unix_seconds))
		else $error("request changed while waiting");

	// A held result stays until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// An empty output stage never back-pressures the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// Time of day fields in range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24))
		else $error("time of day out of range");

	// Calendar fields in range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (day_of_month != 5'd0) && (month < 4'd12) && (weekday < 3'd7)
			&& (year_offset != 8'd0) && (year_offset <= 8'd138)
			&& (day_of_year <= 9'd365))
		else $error("calendar field out of range");

endmodule

bind epoch_seconds_to_utc_calendar_unit esutc_checker u_esutc_checker (.*);

`default_nettype wire
